>>> rtl/bti_pkg.sv
// types and constants for the breakpoint table interpolator
`default_nettype none

package bti_pkg;

   localparam int WL_W       = 16;
   localparam int EFF_W      = 16;
   localparam int IDX_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int PROD_W     = WL_W + EFF_W;
   localparam int DIV_STEPS  = EFF_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W = 40;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LAST,
      ST_CHK_FIRST,
      ST_SCAN,
      ST_MUL0,
      ST_MUL1,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/breakpoint_table_interpolator_core.sv
// breakpoint table with piecewise linear interpolation, one shared multiplier and divider
//
//  channel | direction | handshake              | contents
//  --------+-----------+------------------------+---------------------------------------
//  req     | in        | req_tvalid/req_tready  | load (breakpoint) or query (wavelength)
//  rsp     | out       | rsp_tvalid/rsp_tready  | interpolated efficiency, in_range flag
//  csr     | in        | csr_we                 | point_count
//
//  a query with n active points runs, in order: a check of the last and first entry,
//  a scan of one table entry a cycle, two passes of the 16x16 multiplier and 16 steps
//  of the restoring divider
//  synchronous active high reset clears the sequencer, point_count and rsp_tvalid;
//  the table itself holds garbage until loaded
//  req is taken only while the sequencer is idle; a held result does not block it
module breakpoint_table_interpolator_core
   import bti_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [COUNT_W-1:0]    csr_wdata,     // point_count
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,     // point_index, wavelength, efficiency_value
   input  wire logic                  req_tuser,     // kind
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [EFF_W-1:0]           rsp_tdata,     // efficiency
   output logic                       rsp_tuser      // in_range
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    point_count_ff;
   logic [WL_W-1:0]       q_ff, q_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [WL_W-1:0]       rd_wl_ff;
   logic [EFF_W-1:0]      rd_eff_ff;
   logic [WL_W-1:0]       prev_wl_ff, prev_wl_in;
   logic [EFF_W-1:0]      prev_eff_ff, prev_eff_in;
   logic [WL_W-1:0]       seg_wl_ff, seg_wl_in;
   logic [EFF_W-1:0]      seg_eff_ff, seg_eff_in;
   logic [WL_W-1:0]       span_ff, span_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [WL_W-1:0]       rem_ff, rem_in;
   logic [EFF_W-1:0]      quo_ff, quo_in;
   logic                  inr_ff, inr_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EFF_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [WL_W-1:0]       wl_mem  [MAX_POINTS];
   logic [EFF_W-1:0]      eff_mem [MAX_POINTS];

   logic [IDX_W-1:0]      req_idx;
   logic [WL_W-1:0]       req_wl;
   logic [EFF_W-1:0]      req_eff;
   logic                  req_fire;
   logic                  load_fire;
   logic                  load_ok;
   logic [NW-1:0]         count_ext;
   logic [NW-1:0]         n_active;
   logic [AW-1:0]         last_addr;
   logic                  hit;
   logic [EFF_W-1:0]      mul_a;
   logic [WL_W-1:0]       mul_b;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W-1:0]     sum;
   logic [WL_W:0]         trial;
   logic [WL_W:0]         diff;
   logic                  trial_ge;
   logic                  rsp_free;

   assign req_idx   = req_tdata[IDX_W-1:0];
   assign req_wl    = req_tdata[IDX_W+WL_W-1:IDX_W];
   assign req_eff   = req_tdata[IDX_W+WL_W+EFF_W-1:IDX_W+WL_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign load_ok   = (32'(req_idx) < MAX_POINTS);
   assign load_fire = req_fire && (req_tuser == KIND_LOAD) && load_ok;

   assign count_ext = NW'(point_count_ff);
   assign n_active  = (count_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : count_ext;
   assign last_addr = AW'(n_active - NW'(1));

   assign hit = (prev_wl_ff <= q_ff) && (q_ff < rd_wl_ff);

   assign mul_a = (state_ff == ST_MUL0) ? prev_eff_ff : seg_eff_ff;
   assign mul_b = (state_ff == ST_MUL0) ? (seg_wl_ff - q_ff) : (q_ff - prev_wl_ff);
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign sum   = acc_ff + prod;

   assign trial    = {rem_ff, quo_ff[EFF_W-1]};
   assign diff     = trial - {1'b0, span_ff};
   assign trial_ge = (trial >= {1'b0, span_ff});

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == KIND_QUERY)) begin
               state_in = (n_active < NW'(2)) ? ST_DONE : ST_CHK_LAST;
            end
         end
         ST_CHK_LAST:  state_in = (q_ff >= rd_wl_ff) ? ST_DONE : ST_CHK_FIRST;
         ST_CHK_FIRST: state_in = (q_ff < rd_wl_ff) ? ST_DONE : ST_SCAN;
         ST_SCAN: begin
            priority if (hit) begin
               state_in = ST_MUL0;
            end else if (addr_ff == last_addr) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_in        = q_ff;
      addr_in     = addr_ff;
      prev_wl_in  = prev_wl_ff;
      prev_eff_in = prev_eff_ff;
      seg_wl_in   = seg_wl_ff;
      seg_eff_in  = seg_eff_ff;
      span_in     = span_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      inr_in      = inr_ff;
      div_cnt_in  = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == KIND_QUERY)) begin
               q_in    = req_wl;
               addr_in = last_addr;
               quo_in  = '0;
               inr_in  = 1'b0;
            end
         end
         ST_CHK_LAST: begin
            addr_in = '0;
         end
         ST_CHK_FIRST: begin
            prev_wl_in  = rd_wl_ff;
            prev_eff_in = rd_eff_ff;
            addr_in     = addr_ff + AW'(1);
         end
         ST_SCAN: begin
            if (hit) begin
               seg_wl_in  = rd_wl_ff;
               seg_eff_in = rd_eff_ff;
            end else begin
               prev_wl_in  = rd_wl_ff;
               prev_eff_in = rd_eff_ff;
               addr_in     = addr_ff + AW'(1);
            end
         end
         ST_MUL0: begin
            acc_in  = prod;
            span_in = seg_wl_ff - prev_wl_ff;
         end
         ST_MUL1: begin
            // numerator stays below span * 2^16, so the upper half seeds the remainder
            rem_in     = sum[PROD_W-1:EFF_W];
            quo_in     = sum[EFF_W-1:0];
            inr_in     = 1'b1;
            div_cnt_in = '0;
         end
         ST_DIV: begin
            rem_in     = trial_ge ? diff[WL_W-1:0] : trial[WL_W-1:0];
            quo_in     = {quo_ff[EFF_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = quo_ff;
               rsp_user_in  = inr_ff;
            end
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   // breakpoint table
   always_ff @(posedge clock) begin
      if (load_fire) begin
         wl_mem[AW'(req_idx)]  <= req_wl;
         eff_mem[AW'(req_idx)] <= req_eff;
      end
      rd_wl_ff  <= wl_mem[addr_in];
      rd_eff_ff <= eff_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            point_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      addr_ff     <= addr_in;
      prev_wl_ff  <= prev_wl_in;
      prev_eff_ff <= prev_eff_in;
      seg_wl_ff   <= seg_wl_in;
      seg_eff_ff  <= seg_eff_in;
      span_ff     <= span_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      inr_ff      <= inr_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

>>> sim/breakpoint_table_interpolator_core_tb.sv
// self-checking testbench for the breakpoint table interpolator core
module breakpoint_table_interpolator_core_tb;
   import bti_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int SETTLE_CYCLES = 120;

   typedef struct {
      logic              kind;
      logic [IDX_W-1:0]  point_index;
      logic [WL_W-1:0]   wavelength;
      logic [EFF_W-1:0]  efficiency_value;
   } interp_request_type;

   typedef struct {
      logic [EFF_W-1:0] efficiency;
      logic             in_range;
   } efficiency_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [COUNT_W-1:0]    csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = KIND_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [EFF_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;

   breakpoint_table_interpolator_core #(
      .MAX_POINTS(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   interp_request_type    pending_items[$];
   efficiency_result_type predicted_efficiencies[$];
   int                 error_count = 0;
   int                 items_issued = 0;
   bit                 quiet_mode = 1'b0;
   int                 holds_requested = 0;
   int                 holds_served = 0;

   // predictor copy of the block state
   logic [WL_W-1:0]    bp_wavelength [TABLE_DEPTH];
   logic [EFF_W-1:0]   bp_efficiency [TABLE_DEPTH];
   logic [COUNT_W-1:0] active_count = '0;

   // stimulus side copy, used only to aim queries
   logic [WL_W-1:0]    aim_wavelength [TABLE_DEPTH];
   int                 aim_count = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic efficiency_result_type interpolate_efficiency(input logic [WL_W-1:0] q);
      efficiency_result_type res;
      int                 n;
      longint             span;
      longint             offset;
      longint             e0;
      longint             e1;
      longint             num;
      res.efficiency = '0;
      res.in_range = 1'b0;
      n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
      if (n < 2) return res;
      if (q < bp_wavelength[0] || q >= bp_wavelength[n-1]) return res;
      for (int i = 0; i + 1 < n; i++) begin
         if (q >= bp_wavelength[i] && q < bp_wavelength[i+1]) begin
            span = longint'(bp_wavelength[i+1]) - longint'(bp_wavelength[i]);
            offset = longint'(q) - longint'(bp_wavelength[i]);
            e0 = longint'(bp_efficiency[i]);
            e1 = longint'(bp_efficiency[i+1]);
            num = e0 * span + (e1 - e0) * offset;
            res.efficiency = EFF_W'(num / span);
            res.in_range = 1'b1;
            return res;
         end
      end
      return res;
   endfunction

   // sender
   int send_gap = 0;
   interp_request_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, next_item.efficiency_value, next_item.wavelength,
                          next_item.point_index};
            req_tuser <= next_item.kind;
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   int recv_stall = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
         hold_left = 0;
      end else if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         recv_stall = pick_gap();
      end
   end

   // prediction and checking
   efficiency_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         active_count = '0;
      end else begin
         if (csr_we) active_count = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_LOAD) begin
               bp_wavelength[req_tdata[5:0]] = req_tdata[21:6];
               bp_efficiency[req_tdata[5:0]] = req_tdata[37:22];
            end else begin
               predicted_efficiencies.push_back(interpolate_efficiency(req_tdata[21:6]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_efficiencies.size() == 0) begin
               $error("unexpected item: efficiency %h in_range %b", rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = predicted_efficiencies.pop_front();
               if (rsp_tdata !== want.efficiency) begin
                  $error("efficiency mismatch: expected %h, actual %h",
                         want.efficiency, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.in_range) begin
                  $error("in_range mismatch: expected %b, actual %b", want.in_range, rsp_tuser);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic push_load(input int idx, input int wl, input int eff);
      interp_request_type it;
      it.kind = KIND_LOAD;
      it.point_index = IDX_W'(idx);
      it.wavelength = WL_W'(wl);
      it.efficiency_value = EFF_W'(eff);
      aim_wavelength[idx] = WL_W'(wl);
      pending_items.push_back(it);
      items_issued++;
   endtask

   task automatic push_query(input int wl);
      interp_request_type it;
      it.kind = KIND_QUERY;
      it.point_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.wavelength = WL_W'(wl);
      it.efficiency_value = EFF_W'($urandom_range(0, 65535));
      pending_items.push_back(it);
      items_issued++;
   endtask

   task automatic await_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || predicted_efficiencies.size() != 0);
   endtask

   task automatic write_point_count(input int value);
      await_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= COUNT_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      aim_count = value;
   endtask

   // ascending breakpoints with random spans, duplicates allowed
   task automatic load_ascending_table(input int count);
      int m;
      int wl;
      int step_max;
      m = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      wl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095);
      step_max = $urandom_range(1, (65535 - wl) / ((m > 1) ? m - 1 : 1));
      for (int i = 0; i < m; i++) begin
         if (i > 0) wl = wl + $urandom_range(0, step_max);
         if (i == m - 1 && $urandom_range(0, 7) == 0) wl = 65535;
         push_load(i, wl, $urandom_range(0, 65535));
      end
   endtask

   function automatic int pick_query();
      int m;
      int r;
      m = (aim_count > TABLE_DEPTH) ? TABLE_DEPTH : aim_count;
      r = $urandom_range(0, 99);
      if (r < 70 && m >= 2 && aim_wavelength[m-1] > aim_wavelength[0])
         return $urandom_range(aim_wavelength[0], aim_wavelength[m-1] - 1);
      if (r < 82 && m >= 1)
         return aim_wavelength[$urandom_range(0, m - 1)];
      return $urandom_range(0, 65535);
   endfunction

   initial begin
      int n;
      int m;
      int r;
      int phase;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // full table first so no query touches an unwritten entry
      for (int i = 0; i < TABLE_DEPTH; i++)
         push_load(i, i * 1040, (i < 8) ? ((i % 2) ? 65535 : 0) : $urandom_range(0, 65535));

      // fewer than two points
      push_query(16'h0208);
      push_query(16'hFFFF);
      write_point_count(1);
      push_query(0);
      push_query(500);

      // single segment: at first point, inside, at and above last point
      write_point_count(2);
      push_query(0);
      push_query(520);
      push_query(1039);
      push_query(1040);
      push_query(65535);

      // full table, last entry at the top of the range
      push_load(63, 65535, 65535);
      write_point_count(64);
      push_query(65519);
      push_query(65534);
      push_query(65535);
      push_query(8000);

      // count beyond the table depth
      write_point_count(127);
      push_query(65534);
      push_query(40000);

      // table out of order
      push_load(3, 100, 0);
      write_point_count(5);
      push_query(3000);
      push_query(500);
      push_query(2079);
      push_load(3, 3120, 65535);
      push_query(3200);

      phase = 0;
      while (items_issued < 1350) begin
         r = $urandom_range(0, 99);
         if (r < 8) n = $urandom_range(0, 1);
         else if (r < 70) n = $urandom_range(2, 16);
         else if (r < 85) n = $urandom_range(17, 63);
         else if (r < 93) n = TABLE_DEPTH;
         else n = $urandom_range(65, 127);
         quiet_mode = ($urandom_range(0, 3) == 0);
         load_ascending_table(n);
         write_point_count(n);
         m = $urandom_range(30, 70);
         for (int j = 0; j < m; j++) begin
            if ($urandom_range(0, 99) < 15)
               push_load($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            else
               push_query(pick_query());
         end
         if (phase == 2) holds_requested++;
         phase++;
      end

      await_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #40000000;
      $display("FAILURE");
      $finish;
   end

endmodule
